@@ hdl/iso_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Insulation resistance package
// Shared widths, reset values, register indexes and the per-side status
// that travels down the divider pipeline.
// ---------------------------------------------------------------------------
package iso_pkg;

  // Fixed field widths of the stream and the configuration port
  localparam int CODE_W    = 12;
  localparam int RES_W     = 24;
  localparam int BUS_W     = 20;
  localparam int SCALE_W   = 24;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 2;
  localparam int OHMS_W    = 32;

  // Default converter resolution
  localparam int ADC_BITS_DEF = 12;

  // Operand chunk of the pipelined multiplier
  localparam int MUL_CHUNK = 24;

  // Register reset values
  localparam logic [RES_W-1:0]   R1_RST    = 24'd1000000;
  localparam logic [RES_W-1:0]   R2_RST    = 24'd10000;
  localparam logic [BUS_W-1:0]   BUS_RST   = 20'd400000;
  localparam logic [SCALE_W-1:0] SCALE_RST = 24'd65536;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_R1    = 2'd0,
    REG_R2    = 2'd1,
    REG_BUS   = 2'd2,
    REG_SCALE = 2'd3
  } cfg_reg_e;

  // Per-side status: result not valid, quotient clipped
  typedef struct packed {
    logic bad;
    logic sat;
  } side_t;

endpackage
`default_nettype wire

@@ hdl/iso_mul.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Pipelined signed multiplier
// Splits both operands into chunks, forms the chunk products, sums each
// row and then the rows; three register stages, advanced by en_i.
// ---------------------------------------------------------------------------
module iso_mul #(
  parameter int WA = 25,
  parameter int WB = 25
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic signed [WA-1:0]     a_i,
  input  wire logic signed [WB-1:0]     b_i,
  output logic signed [WA+WB-1:0]       p_o
);

  localparam int CH  = iso_pkg::MUL_CHUNK;
  localparam int NA  = (WA + CH - 1) / CH;
  localparam int NB  = (WB + CH - 1) / CH;
  localparam int SW  = (NA + NB) * CH;
  localparam int PPW = 2 * CH + 2;

  logic signed [NA*CH-1:0] ax;
  logic signed [NB*CH-1:0] bx;
  logic signed [CH:0]      ac [NA];
  logic signed [CH:0]      bc [NB];
  logic signed [PPW-1:0]   pp_q [NA][NB];
  logic signed [SW-1:0]    row_d [NA];
  logic signed [SW-1:0]    row_q [NA];
  logic signed [SW-1:0]    sum_d;
  logic signed [SW-1:0]    p_q;

  assign ax = (NA*CH)'(a_i);
  assign bx = (NB*CH)'(b_i);

  // Cut the operands: low chunks unsigned, top chunk carries the sign
  for (genvar i = 0; i < NA; i++) begin : g_ac
    if (i == NA - 1) begin : g_top
      assign ac[i] = $signed({ax[NA*CH-1], ax[i*CH +: CH]});
    end else begin : g_low
      assign ac[i] = $signed({1'b0, ax[i*CH +: CH]});
    end
  end
  for (genvar j = 0; j < NB; j++) begin : g_bc
    if (j == NB - 1) begin : g_top
      assign bc[j] = $signed({bx[NB*CH-1], bx[j*CH +: CH]});
    end else begin : g_low
      assign bc[j] = $signed({1'b0, bx[j*CH +: CH]});
    end
  end

  // Stage 1: chunk products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_q[i][j] <= ac[i] * bc[j];
        end
      end
    end
  end

  // Stage 2: sum each row of products
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_d[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_d[i] = row_d[i] + (SW'(pp_q[i][j]) <<< (CH * j));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      row_q <= row_d;
    end
  end

  // Stage 3: sum the rows
  always_comb begin
    sum_d = '0;
    for (int i = 0; i < NA; i++) begin
      sum_d = sum_d + (row_q[i] <<< (CH * i));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= sum_d;
    end
  end

  assign p_o = $signed(p_q[WA+WB-1:0]);

endmodule
`default_nettype wire

@@ hdl/iso_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Dual restoring divider
// Divides one magnitude by two divisors, one quotient bit per stage,
// 32 register stages, with status and valid carried alongside.
// ---------------------------------------------------------------------------
module iso_div #(
  parameter int DW = 160
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            en_i,
  input  wire logic                            valid_i,
  input  wire logic [DW-1:0]                   num_i,
  input  wire logic [DW-1:0]                   den_p_i,
  input  wire logic [DW-1:0]                   den_n_i,
  input  wire iso_pkg::side_t                  side_p_i,
  input  wire iso_pkg::side_t                  side_n_i,
  output logic                                 valid_o,
  output logic [iso_pkg::OHMS_W-1:0]           q_p_o,
  output logic [iso_pkg::OHMS_W-1:0]           q_n_o,
  output iso_pkg::side_t                       side_p_o,
  output iso_pkg::side_t                       side_n_o
);

  localparam int QW = iso_pkg::OHMS_W;

  logic                 v_q  [QW];
  logic [DW-1:0]        rp_q [QW];
  logic [DW-1:0]        rn_q [QW];
  logic [DW-1:0]        dp_q [QW];
  logic [DW-1:0]        dn_q [QW];
  logic [QW-1:0]        qp_q [QW];
  logic [QW-1:0]        qn_q [QW];
  iso_pkg::side_t       fp_q [QW];
  iso_pkg::side_t       fn_q [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic                 v_prev;
    logic [DW-1:0]        rp_prev, rn_prev, dp_prev, dn_prev;
    logic [QW-1:0]        qp_prev, qn_prev;
    iso_pkg::side_t       fp_prev, fn_prev;
    logic [DW-1:0]        sp, sn;

    if (s == 0) begin : g_first
      assign v_prev  = valid_i;
      assign rp_prev = num_i;
      assign rn_prev = num_i;
      assign dp_prev = den_p_i;
      assign dn_prev = den_n_i;
      assign qp_prev = '0;
      assign qn_prev = '0;
      assign fp_prev = side_p_i;
      assign fn_prev = side_n_i;
    end else begin : g_next
      assign v_prev  = v_q[s-1];
      assign rp_prev = rp_q[s-1];
      assign rn_prev = rn_q[s-1];
      assign dp_prev = dp_q[s-1];
      assign dn_prev = dn_q[s-1];
      assign qp_prev = qp_q[s-1];
      assign qn_prev = qn_q[s-1];
      assign fp_prev = fp_q[s-1];
      assign fn_prev = fn_q[s-1];
    end

    // Divisor aligned to this stage's quotient bit
    assign sp = dp_prev << (QW - 1 - s);
    assign sn = dn_prev << (QW - 1 - s);

    // Advance the valid bit
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_prev;
      end
    end

    // Trial subtract on both sides
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dp_q[s] <= dp_prev;
        dn_q[s] <= dn_prev;
        fp_q[s] <= fp_prev;
        fn_q[s] <= fn_prev;
        if (rp_prev >= sp) begin
          rp_q[s] <= rp_prev - sp;
          qp_q[s] <= qp_prev | (QW'(1) << (QW - 1 - s));
        end else begin
          rp_q[s] <= rp_prev;
          qp_q[s] <= qp_prev;
        end
        if (rn_prev >= sn) begin
          rn_q[s] <= rn_prev - sn;
          qn_q[s] <= qn_prev | (QW'(1) << (QW - 1 - s));
        end else begin
          rn_q[s] <= rn_prev;
          qn_q[s] <= qn_prev;
        end
      end
    end
  end

  assign valid_o  = v_q[QW-1];
  assign q_p_o    = qp_q[QW-1];
  assign q_n_o    = qn_q[QW-1];
  assign side_p_o = fp_q[QW-1];
  assign side_n_o = fn_q[QW-1];

endmodule
`default_nettype wire

@@ hdl/insulation_resistance_calc.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Each accepted input transaction passes 11 arithmetic stages, the 32-stage
// quotient divider and the output register before its result is on the output.
// Throughput: one transaction per cycle; a full skid stage stalls the input.
// Reset (asynchronous, active low) clears all valid bits and the skid stage
// and loads the register defaults; no clearing pass is needed.
// ---------------------------------------------------------------------------
// Insulation resistance calculator
// Scales four rail readings, forms the switched-divider numerator and both
// denominators in fixed point, divides and clips to whole ohms.
// ---------------------------------------------------------------------------
module insulation_resistance_calc #(
  parameter int ADC_BITS = iso_pkg::ADC_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration write port
  input  wire logic                              cfg_we_i,
  input  wire logic [iso_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [iso_pkg::CFG_W-1:0]         cfg_data_i,
  // input stream
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // pos_ref_code, neg_ref_code, pos_sw_code, neg_sw_code
  input  wire logic [4*iso_pkg::CODE_W-1:0]      s_axis_tdata,
  // output stream
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // iso_pos_ohms, iso_neg_ohms
  output logic [2*iso_pkg::OHMS_W-1:0]           m_axis_tdata,
  // pos_invalid, neg_invalid
  output logic [1:0]                             m_axis_tuser
);

  localparam int CW   = ADC_BITS;
  localparam int RW   = iso_pkg::RES_W;
  localparam int P1W  = CW + RW + 1;
  localparam int P2W  = CW + RW;
  localparam int DRW  = RW + iso_pkg::BUS_W;
  localparam int EW   = CW + 27;
  localparam int UW   = iso_pkg::SCALE_W + 1;
  localparam int DSW  = iso_pkg::BUS_W + 1;
  localparam int UEW  = UW + EW;
  localparam int TP1W = DSW + EW;
  localparam int TP2W = P1W + EW;
  localparam int NBW  = UEW + 1;
  localparam int DIW  = ((TP1W + 16 > TP2W) ? TP1W + 16 : TP2W) + 1;
  localparam int NPW  = DRW + 1 + NBW;
  localparam int NUMW = NPW + 16;
  localparam int DENW = UW + DIW;
  localparam int DW   = (NUMW > DENW + 32) ? NUMW : DENW + 32;
  localparam int OW   = iso_pkg::OHMS_W;
  localparam int FW   = iso_pkg::CODE_W;

  // Configuration registers
  logic [RW-1:0]                  r1_q, r2_q;
  logic [iso_pkg::BUS_W-1:0]      bus_q;
  logic [iso_pkg::SCALE_W-1:0]    scale_q;
  logic [DRW-1:0]                 dr1_q, dr2_q;

  logic                           en;
  logic [CW-1:0]                  cp, cn, c1, c2;
  logic [RW:0]                    rsum;

  logic                           v1_q, v2_q, v6_q, v10_q, v11_q;
  logic [2:0]                     m1v_q, m2v_q;
  logic [P1W-1:0]                 p1_q, p3_q;
  logic [P2W-1:0]                 p2_q, p4_q, p5_q, p6_q, p9_q, p10_q;
  logic [P2W-1:0]                 ucp2_q, ucn2_q;
  logic signed [EW-1:0]           e_q, xp_q, xn_q;
  logic signed [EW-1:0]           e_d, xp_d, xn_d;
  logic signed [UW-1:0]           u_s;
  logic signed [DSW-1:0]          d_s;
  logic signed [UEW-1:0]          ue;
  logic signed [TP1W-1:0]         tp1, tn1;
  logic signed [TP2W-1:0]         tp2, tn2;
  logic signed [NBW-1:0]          numb_q;
  logic signed [DIW-1:0]          dinp_q, dinn_q;
  logic signed [NPW-1:0]          nprod;
  logic signed [DENW-1:0]         denp, denn;
  logic signed [NUMW-1:0]         num;
  logic [DW-1:0]                  na10_q, dpa10_q, dna10_q;
  logic                           badp10_q, badn10_q;
  logic [DW-1:0]                  na11_q, dpa11_q, dna11_q;
  iso_pkg::side_t                 sp11_q, sn11_q;

  logic                           dv;
  logic [OW-1:0]                  qp, qn;
  iso_pkg::side_t                 fp, fn;
  logic [OW-1:0]                  pos_ohms, neg_ohms;
  logic                           pos_inv, neg_inv;
  logic                           out_v_q, skid_v_q;
  logic [2*OW+1:0]                res_d, out_q, skid_q;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_q    <= iso_pkg::R1_RST;
      r2_q    <= iso_pkg::R2_RST;
      bus_q   <= iso_pkg::BUS_RST;
      scale_q <= iso_pkg::SCALE_RST;
    end else if (cfg_we_i) begin
      case (iso_pkg::cfg_reg_e'(cfg_idx_i))
        iso_pkg::REG_R1:    r1_q    <= cfg_data_i[RW-1:0];
        iso_pkg::REG_R2:    r2_q    <= cfg_data_i[RW-1:0];
        iso_pkg::REG_BUS:   bus_q   <= cfg_data_i[iso_pkg::BUS_W-1:0];
        iso_pkg::REG_SCALE: scale_q <= cfg_data_i[iso_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold bus voltage times each sense resistor
  always_ff @(posedge clk_i) begin
    dr1_q <= DRW'(bus_q) * DRW'(r1_q);
    dr2_q <= DRW'(bus_q) * DRW'(r2_q);
  end

  // Pipeline advances while the skid stage is free
  assign en            = !skid_v_q;
  assign s_axis_tready = en;

  // Take the low converter bits of each code, or widen a code narrower than CW
  if (CW <= FW) begin : g_code_cut
    assign cp = s_axis_tdata[0*FW +: CW];
    assign cn = s_axis_tdata[1*FW +: CW];
    assign c1 = s_axis_tdata[2*FW +: CW];
    assign c2 = s_axis_tdata[3*FW +: CW];
  end else begin : g_code_ext
    assign cp = CW'(s_axis_tdata[0*FW +: FW]);
    assign cn = CW'(s_axis_tdata[1*FW +: FW]);
    assign c1 = CW'(s_axis_tdata[2*FW +: FW]);
    assign c2 = CW'(s_axis_tdata[3*FW +: FW]);
  end

  assign rsum = (RW+1)'(r1_q) + (RW+1)'(r2_q);
  assign u_s  = $signed({1'b0, scale_q});
  assign d_s  = $signed({1'b0, bus_q});

  // Valid bits of the arithmetic stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      m1v_q <= '0;
      v6_q  <= 1'b0;
      m2v_q <= '0;
      v10_q <= 1'b0;
      v11_q <= 1'b0;
    end else if (en) begin
      v1_q  <= s_axis_tvalid;
      v2_q  <= v1_q;
      m1v_q <= {m1v_q[1:0], v2_q};
      v6_q  <= m1v_q[2];
      m2v_q <= {m2v_q[1:0], v6_q};
      v10_q <= m2v_q[2];
      v11_q <= v10_q;
    end
  end

  // Stage 1: code by resistor and code by scale products
  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q  <= P1W'(cp) * P1W'(rsum);
      p3_q  <= P1W'(cn) * P1W'(rsum);
      p2_q  <= P2W'(r2_q) * P2W'(c1);
      p4_q  <= P2W'(r2_q) * P2W'(c2);
      p5_q  <= P2W'(r1_q) * P2W'(cp);
      p6_q  <= P2W'(r1_q) * P2W'(cn);
      p9_q  <= P2W'(scale_q) * P2W'(cp);
      p10_q <= P2W'(scale_q) * P2W'(cn);
    end
  end

  // Stage 2: alpha and beta terms, their difference and the rail offsets
  assign e_d  = EW'(p3_q) - EW'(p4_q) - EW'(p1_q) + EW'(p2_q);
  assign xp_d = EW'(p5_q) - EW'(p3_q) + EW'(p4_q);
  assign xn_d = EW'(p6_q) - EW'(p1_q) + EW'(p2_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_q    <= e_d;
      xp_q   <= xp_d;
      xn_q   <= xn_d;
      ucp2_q <= p9_q;
      ucn2_q <= p10_q;
    end
  end

  // Stages 3 to 5: first product layer
  iso_mul #(.WA(UW), .WB(EW)) u_mul_ue (
    .clk_i, .en_i(en), .a_i(u_s), .b_i(e_q), .p_o(ue)
  );
  iso_mul #(.WA(DSW), .WB(EW)) u_mul_tp1 (
    .clk_i, .en_i(en), .a_i(d_s), .b_i(xp_q), .p_o(tp1)
  );
  iso_mul #(.WA(DSW), .WB(EW)) u_mul_tn1 (
    .clk_i, .en_i(en), .a_i(d_s), .b_i(xn_q), .p_o(tn1)
  );
  iso_mul #(.WA(P1W), .WB(EW)) u_mul_tp2 (
    .clk_i, .en_i(en), .a_i($signed({1'b0, ucp2_q})), .b_i(e_q), .p_o(tp2)
  );
  iso_mul #(.WA(P1W), .WB(EW)) u_mul_tn2 (
    .clk_i, .en_i(en), .a_i($signed({1'b0, ucn2_q})), .b_i(e_q), .p_o(tn2)
  );

  // Stage 6: numerator factor and the two denominator sums
  always_ff @(posedge clk_i) begin
    if (en) begin
      numb_q <= NBW'($signed({1'b0, dr1_q, 16'b0})) + NBW'(ue);
      dinp_q <= DIW'($signed({tp1, 16'b0})) + DIW'(tp2);
      dinn_q <= DIW'($signed({tn1, 16'b0})) + DIW'(tn2);
    end
  end

  // Stages 7 to 9: second product layer
  iso_mul #(.WA(DRW + 1), .WB(NBW)) u_mul_num (
    .clk_i, .en_i(en), .a_i($signed({1'b0, dr2_q})), .b_i(numb_q), .p_o(nprod)
  );
  iso_mul #(.WA(UW), .WB(DIW)) u_mul_denp (
    .clk_i, .en_i(en), .a_i(u_s), .b_i(dinp_q), .p_o(denp)
  );
  iso_mul #(.WA(UW), .WB(DIW)) u_mul_denn (
    .clk_i, .en_i(en), .a_i(u_s), .b_i(dinn_q), .p_o(denn)
  );

  assign num = $signed({nprod, 16'b0});

  // Stage 10: magnitudes and sign or zero rejects
  always_ff @(posedge clk_i) begin
    if (en) begin
      na10_q   <= DW'($unsigned(num[NUMW-1] ? -num : num));
      dpa10_q  <= DW'($unsigned(denp[DENW-1] ? -denp : denp));
      dna10_q  <= DW'($unsigned(denn[DENW-1] ? -denn : denn));
      badp10_q <= (denp == '0) || (num == '0) || (num[NUMW-1] != denp[DENW-1]);
      badn10_q <= (denn == '0) || (num == '0) || (num[NUMW-1] != denn[DENW-1]);
    end
  end

  // Stage 11: clip check against the divisor times 2^32
  always_ff @(posedge clk_i) begin
    if (en) begin
      na11_q     <= na10_q;
      dpa11_q    <= dpa10_q;
      dna11_q    <= dna10_q;
      sp11_q.bad <= badp10_q;
      sn11_q.bad <= badn10_q;
      sp11_q.sat <= na10_q >= (dpa10_q << OW);
      sn11_q.sat <= na10_q >= (dna10_q << OW);
    end
  end

  // Stages 12 to 43: quotient bits
  iso_div #(.DW(DW)) u_div (
    .clk_i,
    .rst_ni,
    .en_i     (en),
    .valid_i  (v11_q),
    .num_i    (na11_q),
    .den_p_i  (dpa11_q),
    .den_n_i  (dna11_q),
    .side_p_i (sp11_q),
    .side_n_i (sn11_q),
    .valid_o  (dv),
    .q_p_o    (qp),
    .q_n_o    (qn),
    .side_p_o (fp),
    .side_n_o (fn)
  );

  // Resolve rejects, clipping and a zero first resistor
  always_comb begin
    pos_ohms = fp.sat ? '1 : qp;
    neg_ohms = fn.sat ? '1 : qn;
    pos_inv  = fp.bad || (!fp.sat && (qp == '0));
    neg_inv  = fn.bad || (!fn.sat && (qn == '0));
    if (pos_inv || (r1_q == '0)) begin
      pos_ohms = '0;
      pos_inv  = 1'b1;
    end
    if (neg_inv || (r1_q == '0)) begin
      neg_ohms = '0;
      neg_inv  = 1'b1;
    end
    res_d = {neg_inv, pos_inv, neg_ohms, pos_ohms};
  end

  // Output register with skid stage: control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || m_axis_tready) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q  <= dv;
      end
    end else if (en && dv) begin
      skid_v_q <= 1'b1;
    end
  end

  // Output register with skid stage: payload
  always_ff @(posedge clk_i) begin
    if (!out_v_q || m_axis_tready) begin
      out_q <= skid_v_q ? skid_q : res_d;
    end else if (en) begin
      skid_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q[2*OW-1:0];
  assign m_axis_tuser  = out_q[2*OW+1:2*OW];

  // Skid stage only holds data behind a held output
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid stage full with empty output register");

  // Skid stage fills only from a stalled output
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && !m_axis_tready))
    else $error("skid stage filled without output stall");

  // A rejected side reports zero ohms
  a_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[OW-1:0] == '0))
    else $error("positive side rejected with nonzero ohms");

  a_neg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata[2*OW-1:OW] == '0))
    else $error("negative side rejected with nonzero ohms");

endmodule
`default_nettype wire
